>>> hdl/pauli_frame_tracker_defines.svh
// ----------------------------------------------------------------------------
// pauli_frame_tracker_defines
// assertion macros shared by the frame tracker rtl
// ----------------------------------------------------------------------------
`ifndef PAULI_FRAME_TRACKER_DEFINES_SVH
`define PAULI_FRAME_TRACKER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define PFT_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define PFT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/pft_pkg.sv
// ----------------------------------------------------------------------------
// pft_pkg
// shared widths, codes, defaults and helpers for the pauli frame tracker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pft_pkg;

    // field widths
    localparam int MODE_W    = 4;
    localparam int QIDX_W    = 6;
    localparam int RAND_W    = 16;
    localparam int COND_W    = 2;
    localparam int CEIL_W    = 17;
    localparam int CFG_IDX_W = 2;
    localparam int TAG_W     = 2;

    // parameter defaults
    localparam int DEF_NUM_QUBITS = 64;
    localparam int DEF_RAND_BITS  = 16;

    // one as a fraction of 2^16
    localparam logic [CEIL_W-1:0] FRAC_ONE = 17'h10000;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_FREE    = 4'd0;
    localparam logic [MODE_W-1:0] MODE_EMIT    = 4'd1;
    localparam logic [MODE_W-1:0] MODE_X       = 4'd2;
    localparam logic [MODE_W-1:0] MODE_Z       = 4'd3;
    localparam logic [MODE_W-1:0] MODE_H       = 4'd4;
    localparam logic [MODE_W-1:0] MODE_CNOT    = 4'd5;
    localparam logic [MODE_W-1:0] MODE_MEAS_X  = 4'd6;
    localparam logic [MODE_W-1:0] MODE_MEAS_Y  = 4'd7;
    localparam logic [MODE_W-1:0] MODE_MEAS_Z  = 4'd8;
    localparam logic [MODE_W-1:0] MODE_MIXED   = 4'd9;
    localparam logic [MODE_W-1:0] MODE_EXCITED = 4'd10;
    localparam logic [MODE_W-1:0] MODE_RELAXED = 4'd11;

    // condition codes
    localparam logic [COND_W-1:0] COND_CLEAN   = 2'd0;
    localparam logic [COND_W-1:0] COND_MIXED   = 2'd1;
    localparam logic [COND_W-1:0] COND_EXCITED = 2'd2;
    localparam logic [COND_W-1:0] COND_RELAXED = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NO_ERROR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_ERROR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_ERROR  = 2'd2;

    // per-entry condition source: forced clean, forced mixed, or from the ram
    localparam logic [TAG_W-1:0] TAG_CLEAN  = 2'd0;
    localparam logic [TAG_W-1:0] TAG_MIXED  = 2'd1;
    localparam logic [TAG_W-1:0] TAG_STORED = 2'd2;

    // error picked by the emission sampler
    typedef struct packed {
        logic set_x;
        logic set_z;
    } emit_band_t;

    // ceilings above one count as one
    function automatic logic [CEIL_W-1:0] sat_ceiling(input logic [CEIL_W-1:0] c);
        return (c > FRAC_ONE) ? FRAC_ONE : c;
    endfunction

endpackage

>>> hdl/pft_ram.sv
// ----------------------------------------------------------------------------
// pft_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pft_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read, returns the old contents on a same-cycle write
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/pft_emit_sampler.sv
// ----------------------------------------------------------------------------
// pft_emit_sampler
// maps a random fraction onto the no-error, x, z and y bands
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pft_emit_sampler #(
    parameter int RAND_BITS = pft_pkg::DEF_RAND_BITS
) (
    input  logic [pft_pkg::RAND_W-1:0] random_value,
    input  logic [pft_pkg::CEIL_W-1:0] no_error_ceiling,
    input  logic [pft_pkg::CEIL_W-1:0] x_error_ceiling,
    input  logic [pft_pkg::CEIL_W-1:0] z_error_ceiling,
    output pft_pkg::emit_band_t        band
);

    import pft_pkg::*;

    // align the random value and the ceilings on a common scale
    localparam int SH_R  = (RAND_BITS < RAND_W) ? (RAND_W - RAND_BITS) : 0;
    localparam int SH_C  = (RAND_BITS > RAND_W) ? (RAND_BITS - RAND_W) : 0;
    localparam int R_W   = RAND_W + SH_R;
    localparam int C_W   = CEIL_W + SH_C;
    localparam int CMP_W = (R_W > C_W) ? R_W : C_W;
    localparam logic [RAND_W-1:0] RND_MASK = (RAND_BITS >= RAND_W) ? {RAND_W{1'b1}} :
        RAND_W'((64'd1 << RAND_BITS) - 64'd1);

    logic [RAND_W-1:0] rnd_m;
    logic [CMP_W-1:0]  r;
    logic [CMP_W-1:0]  ne;
    logic [CMP_W-1:0]  xe;
    logic [CMP_W-1:0]  ze;
    logic [CMP_W-1:0]  one;

    // scaled operands
    always_comb
    begin
        rnd_m = random_value & RND_MASK;
        r     = CMP_W'(rnd_m) << SH_R;
        ne    = CMP_W'(sat_ceiling(no_error_ceiling)) << SH_C;
        xe    = CMP_W'(sat_ceiling(x_error_ceiling)) << SH_C;
        ze    = CMP_W'(sat_ceiling(z_error_ceiling)) << SH_C;
        one   = CMP_W'(FRAC_ONE) << SH_C;
    end

    // band selection, first match wins
    always_comb
    begin
        band.set_x = 1'b0;
        band.set_z = 1'b0;
        priority if (r < ne)
        begin
            band.set_x = 1'b0;
        end
        else if (r < xe && ne != xe)
        begin
            band.set_x = 1'b1;
        end
        else if (r >= xe && r < ze && xe != ze)
        begin
            band.set_z = 1'b1;
        end
        else if (r >= ze && r < one && ze != one)
        begin
            band.set_x = 1'b1;
            band.set_z = 1'b1;
        end
        else
        begin
            band.set_x = 1'b0;
        end
    end

endmodule

>>> hdl/pauli_frame_tracker.sv
// Path: a request passes the request register, then the result register.
// Throughput: one request per cycle unless out_stall holds a result, set by the
// single read-modify-write pass over the frame rams, bypassing the previous request's write.
// Reset: flag-clear bits and condition tags reset so every entry reads clean;
// ceilings reset to one; no clearing pass, requests are taken right away.
// ----------------------------------------------------------------------------
// pauli_frame_tracker
// table of qubit pauli error frames with emission sampling and gate updates
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pauli_frame_tracker_defines.svh"

module pauli_frame_tracker #(
    parameter int NUM_QUBITS = pft_pkg::DEF_NUM_QUBITS,
    parameter int RAND_BITS  = pft_pkg::DEF_RAND_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration
    input  logic                        cfg_we,
    input  logic [pft_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pft_pkg::CEIL_W-1:0]  cfg_data,
    // request channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [pft_pkg::MODE_W-1:0]  mode,
    input  logic [pft_pkg::QIDX_W-1:0]  qubit_index,
    input  logic [pft_pkg::QIDX_W-1:0]  partner_index,
    input  logic                        partner_valid,
    input  logic [pft_pkg::RAND_W-1:0]  random_value,
    // result channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        x_flag,
    output logic                        z_flag,
    output logic [pft_pkg::COND_W-1:0]  condition,
    output logic                        outcome_correct,
    output logic                        fault
);

    import pft_pkg::*;

    localparam int IDX_W = (NUM_QUBITS > 1) ? $clog2(NUM_QUBITS) : 1;

    // configuration registers
    logic [CEIL_W-1:0] no_error_ceiling_reg;
    logic [CEIL_W-1:0] x_error_ceiling_reg;
    logic [CEIL_W-1:0] z_error_ceiling_reg;

    // request register
    logic              s1_valid_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [QIDX_W-1:0] q_reg;
    logic [QIDX_W-1:0] p_reg;
    logic              pv_reg;
    logic [RAND_W-1:0] rnd_reg;

    // result register
    logic              res_valid_reg;
    logic              res_x_reg;
    logic              res_z_reg;
    logic [COND_W-1:0] res_cond_reg;
    logic              res_ok_reg;
    logic              res_fault_reg;

    // per-entry override state
    logic [NUM_QUBITS-1:0] x_clr_reg;
    logic [NUM_QUBITS-1:0] x_clr_next;
    logic [NUM_QUBITS-1:0] z_clr_reg;
    logic [NUM_QUBITS-1:0] z_clr_next;
    logic [TAG_W-1:0]      tag_reg  [NUM_QUBITS];
    logic [TAG_W-1:0]      tag_next [NUM_QUBITS];

    // last write of each ram, for the bypass
    logic              x_wr_valid_reg;
    logic [IDX_W-1:0]  x_wr_addr_reg;
    logic              x_wr_data_reg;
    logic              z_wr_valid_reg;
    logic [IDX_W-1:0]  z_wr_addr_reg;
    logic              z_wr_data_reg;
    logic              c_wr_valid_reg;
    logic [IDX_W-1:0]  c_wr_addr_reg;
    logic [COND_W-1:0] c_wr_data_reg;

    // handshake
    logic in_accept;
    logic s1_adv;
    logic s1_fire;
    logic eff;

    // ram ports
    logic [IDX_W-1:0]  rq_addr;
    logic [IDX_W-1:0]  rp_addr;
    logic [0:0]        x_rdq;
    logic [0:0]        x_rdp;
    logic [0:0]        z_rdq;
    logic [0:0]        z_rdp;
    logic [COND_W-1:0] c_rdq;
    logic              x_we;
    logic              x_wdata;
    logic              z_we;
    logic [IDX_W-1:0]  z_waddr;
    logic              z_wdata;
    logic              c_we;
    logic [COND_W-1:0] c_wdata;

    // datapath
    logic [IDX_W-1:0]  q_idx;
    logic [IDX_W-1:0]  p_idx;
    logic              q_in;
    logic              p_in;
    logic              x_q_st;
    logic              x_p_st;
    logic              z_q_st;
    logic              z_p_st;
    logic [COND_W-1:0] c_q_st;
    logic              xq;
    logic              xp;
    logic              zq;
    logic              zp;
    logic [TAG_W-1:0]  tag_q;
    logic [COND_W-1:0] cq;
    logic              clr_q;
    logic              tag_q_we;
    logic [TAG_W-1:0]  tag_q_val;
    logic              mark_p;
    logic              post_x;
    logic              post_z;
    logic [COND_W-1:0] post_c;
    logic              ok;
    logic              flt;
    emit_band_t        band;

    // handshake control
    assign s1_adv    = !res_valid_reg || !out_stall;
    assign s1_fire   = s1_valid_reg && s1_adv;
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_accept = in_valid && !in_stall;
    assign out_valid = res_valid_reg;

    assign q_idx = IDX_W'(q_reg);
    assign p_idx = IDX_W'(p_reg);
    assign q_in  = (32'(q_reg) < NUM_QUBITS);
    assign p_in  = (32'(p_reg) < NUM_QUBITS);
    assign eff   = s1_fire && q_in;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            no_error_ceiling_reg <= FRAC_ONE;
            x_error_ceiling_reg  <= FRAC_ONE;
            z_error_ceiling_reg  <= FRAC_ONE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NO_ERROR: no_error_ceiling_reg <= cfg_data;
                CFG_X_ERROR:  x_error_ceiling_reg  <= cfg_data;
                CFG_Z_ERROR:  z_error_ceiling_reg  <= cfg_data;
                default:      no_error_ceiling_reg <= no_error_ceiling_reg;
            endcase
        end
    end

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mode_reg <= mode;
            q_reg    <= qubit_index;
            p_reg    <= partner_index;
            pv_reg   <= partner_valid;
            rnd_reg  <= random_value;
        end
    end

    // rams read at the incoming request, or re-read for a held one
    assign rq_addr = in_accept ? IDX_W'(qubit_index) : q_idx;
    assign rp_addr = in_accept ? IDX_W'(partner_index) : p_idx;

    pft_ram #(.WIDTH(1), .DEPTH(NUM_QUBITS)) u_x_ram_q (
        .clk   (clk),
        .we    (eff && x_we),
        .waddr (q_idx),
        .wdata (x_wdata),
        .raddr (rq_addr),
        .rdata (x_rdq)
    );

    pft_ram #(.WIDTH(1), .DEPTH(NUM_QUBITS)) u_x_ram_p (
        .clk   (clk),
        .we    (eff && x_we),
        .waddr (q_idx),
        .wdata (x_wdata),
        .raddr (rp_addr),
        .rdata (x_rdp)
    );

    pft_ram #(.WIDTH(1), .DEPTH(NUM_QUBITS)) u_z_ram_q (
        .clk   (clk),
        .we    (eff && z_we),
        .waddr (z_waddr),
        .wdata (z_wdata),
        .raddr (rq_addr),
        .rdata (z_rdq)
    );

    pft_ram #(.WIDTH(1), .DEPTH(NUM_QUBITS)) u_z_ram_p (
        .clk   (clk),
        .we    (eff && z_we),
        .waddr (z_waddr),
        .wdata (z_wdata),
        .raddr (rp_addr),
        .rdata (z_rdp)
    );

    pft_ram #(.WIDTH(COND_W), .DEPTH(NUM_QUBITS)) u_cond_ram (
        .clk   (clk),
        .we    (eff && c_we),
        .waddr (q_idx),
        .wdata (c_wdata),
        .raddr (rq_addr),
        .rdata (c_rdq)
    );

    // emission sampling
    pft_emit_sampler #(.RAND_BITS(RAND_BITS)) u_emit (
        .random_value     (rnd_reg),
        .no_error_ceiling (no_error_ceiling_reg),
        .x_error_ceiling  (x_error_ceiling_reg),
        .z_error_ceiling  (z_error_ceiling_reg),
        .band             (band)
    );

    // bypass of the most recent ram write
    always_comb
    begin
        x_q_st = (x_wr_valid_reg && x_wr_addr_reg == q_idx) ? x_wr_data_reg : x_rdq[0];
        x_p_st = (x_wr_valid_reg && x_wr_addr_reg == p_idx) ? x_wr_data_reg : x_rdp[0];
        z_q_st = (z_wr_valid_reg && z_wr_addr_reg == q_idx) ? z_wr_data_reg : z_rdq[0];
        z_p_st = (z_wr_valid_reg && z_wr_addr_reg == p_idx) ? z_wr_data_reg : z_rdp[0];
        c_q_st = (c_wr_valid_reg && c_wr_addr_reg == q_idx) ? c_wr_data_reg : c_rdq;
    end

    // current entry values after overrides
    always_comb
    begin
        xq    = q_in && !x_clr_reg[q_idx] && x_q_st;
        zq    = q_in && !z_clr_reg[q_idx] && z_q_st;
        xp    = p_in && !x_clr_reg[p_idx] && x_p_st;
        zp    = p_in && !z_clr_reg[p_idx] && z_p_st;
        tag_q = q_in ? tag_reg[q_idx] : TAG_CLEAN;
        unique case (tag_q)
            TAG_CLEAN:  cq = COND_CLEAN;
            TAG_MIXED:  cq = COND_MIXED;
            TAG_STORED: cq = c_q_st;
            default:    cq = COND_CLEAN;
        endcase
    end

    // operation decode
    always_comb
    begin
        x_we      = 1'b0;
        x_wdata   = 1'b0;
        z_we      = 1'b0;
        z_waddr   = q_idx;
        z_wdata   = 1'b0;
        c_we      = 1'b0;
        c_wdata   = COND_CLEAN;
        clr_q     = 1'b0;
        tag_q_we  = 1'b0;
        tag_q_val = TAG_CLEAN;
        mark_p    = 1'b0;
        post_x    = xq;
        post_z    = zq;
        post_c    = cq;
        ok        = 1'b0;
        flt       = 1'b0;
        unique case (mode_reg)
            MODE_FREE:
            begin
                clr_q     = 1'b1;
                tag_q_we  = 1'b1;
                tag_q_val = TAG_CLEAN;
                post_x    = 1'b0;
                post_z    = 1'b0;
                post_c    = COND_CLEAN;
            end
            MODE_EMIT:
            begin
                if (xq || zq)
                begin
                    flt = 1'b1;
                end
                else
                begin
                    x_we    = 1'b1;
                    x_wdata = band.set_x;
                    z_we    = 1'b1;
                    z_wdata = band.set_z;
                    post_x  = band.set_x;
                    post_z  = band.set_z;
                end
            end
            MODE_X:
            begin
                x_we    = 1'b1;
                x_wdata = !xq;
                post_x  = !xq;
            end
            MODE_Z:
            begin
                z_we    = 1'b1;
                z_wdata = !zq;
                post_z  = !zq;
            end
            MODE_H:
            begin
                x_we    = 1'b1;
                x_wdata = zq;
                z_we    = 1'b1;
                z_wdata = xq;
                post_x  = zq;
                post_z  = xq;
            end
            MODE_CNOT:
            begin
                if (p_reg == q_reg)
                begin
                    flt = 1'b1;
                end
                else if (p_in)
                begin
                    x_we    = 1'b1;
                    x_wdata = xq ^ xp;
                    z_we    = 1'b1;
                    z_waddr = p_idx;
                    z_wdata = zp ^ zq;
                    post_x  = xq ^ xp;
                end
            end
            MODE_MEAS_X: ok = !zq;
            MODE_MEAS_Y: ok = !(xq || zq);
            MODE_MEAS_Z: ok = !xq;
            MODE_MIXED:
            begin
                clr_q     = 1'b1;
                tag_q_we  = 1'b1;
                tag_q_val = TAG_MIXED;
                post_x    = 1'b0;
                post_z    = 1'b0;
                post_c    = COND_MIXED;
            end
            MODE_EXCITED, MODE_RELAXED:
            begin
                clr_q     = 1'b1;
                c_we      = 1'b1;
                c_wdata   = (mode_reg == MODE_EXCITED) ? COND_EXCITED : COND_RELAXED;
                tag_q_we  = 1'b1;
                tag_q_val = TAG_STORED;
                post_x    = 1'b0;
                post_z    = 1'b0;
                post_c    = c_wdata;
                // partner goes mixed, also when it is the entry itself
                if (pv_reg && p_in)
                begin
                    mark_p = 1'b1;
                    if (p_reg == q_reg)
                    begin
                        post_c = COND_MIXED;
                    end
                end
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    // override state next values, partner update last
    always_comb
    begin
        x_clr_next = x_clr_reg;
        z_clr_next = z_clr_reg;
        tag_next   = tag_reg;
        if (eff)
        begin
            if (x_we)
            begin
                x_clr_next[q_idx] = 1'b0;
            end
            if (z_we)
            begin
                z_clr_next[z_waddr] = 1'b0;
            end
            if (clr_q)
            begin
                x_clr_next[q_idx] = 1'b1;
                z_clr_next[q_idx] = 1'b1;
            end
            if (tag_q_we)
            begin
                tag_next[q_idx] = tag_q_val;
            end
            if (mark_p)
            begin
                x_clr_next[p_idx] = 1'b1;
                z_clr_next[p_idx] = 1'b1;
                tag_next[p_idx]   = TAG_MIXED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_clr_reg <= {NUM_QUBITS{1'b1}};
            z_clr_reg <= {NUM_QUBITS{1'b1}};
            for (int i = 0; i < NUM_QUBITS; i++)
            begin
                tag_reg[i] <= TAG_CLEAN;
            end
        end
        else
        begin
            x_clr_reg <= x_clr_next;
            z_clr_reg <= z_clr_next;
            tag_reg   <= tag_next;
        end
    end

    // bypass records
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_wr_valid_reg <= 1'b0;
            z_wr_valid_reg <= 1'b0;
            c_wr_valid_reg <= 1'b0;
        end
        else
        begin
            if (eff && x_we)
            begin
                x_wr_valid_reg <= 1'b1;
            end
            if (eff && z_we)
            begin
                z_wr_valid_reg <= 1'b1;
            end
            if (eff && c_we)
            begin
                c_wr_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (eff && x_we)
        begin
            x_wr_addr_reg <= q_idx;
            x_wr_data_reg <= x_wdata;
        end
        if (eff && z_we)
        begin
            z_wr_addr_reg <= z_waddr;
            z_wr_data_reg <= z_wdata;
        end
        if (eff && c_we)
        begin
            c_wr_addr_reg <= q_idx;
            c_wr_data_reg <= c_wdata;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            res_x_reg     <= q_in && post_x;
            res_z_reg     <= q_in && post_z;
            res_cond_reg  <= q_in ? post_c : COND_CLEAN;
            res_ok_reg    <= q_in && ok;
            res_fault_reg <= q_in && flt;
        end
    end

    assign x_flag          = res_x_reg;
    assign z_flag          = res_z_reg;
    assign condition       = res_cond_reg;
    assign outcome_correct = res_ok_reg;
    assign fault           = res_fault_reg;

    // checks
    `PFT_ASSERT_IMPLIES(a_stall_needs_item, in_stall, s1_valid_reg, "stall with empty request register")
    `PFT_ASSERT_IMPLIES(a_fault_no_write, s1_fire && flt, !x_we && !z_we && !c_we && !clr_q, "faulting request changes the table")
    `PFT_ASSERT_IMPLIES(a_fault_not_measure, out_valid && fault, !outcome_correct, "fault reported with a correct outcome")
    `PFT_ASSERT_NEXT(a_fire_gives_result, s1_fire, out_valid, "request left without a result")

endmodule
